@@ rtl/core/xtea_pkg.sv @@
// Shared constants and round functions for the XTEA block encryption unit.
package xtea_pkg;

  localparam int WORD_W     = 32;
  localparam int BLOCK_W    = 2 * WORD_W;
  localparam int ROUNDS_DEF = 32;
  localparam int CFG_IDX_W  = 8;

  // Amount added to the running sum once per round
  localparam logic [WORD_W-1:0] SUM_STEP = 32'h9E37_79B9;

  // Key register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D = 8'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Running sum after n step additions, wrapped to 32 bits
  function automatic word_t round_sum(input int n);
    logic [63:0] prod;
    begin
      prod = 64'(n) * 64'(SUM_STEP);
      return prod[WORD_W-1:0];
    end
  endfunction

  // One half-round mixing term: (((v << 4) ^ (v >> 5)) + v) ^ (s + k)
  function automatic word_t mix_word(input word_t v, input word_t s, input word_t k);
    word_t f;
    begin
      f = ((v << 4) ^ (v >> 5)) + v;
      return f ^ (s + k);
    end
  endfunction

endpackage

@@ rtl/core/xtea_block_encrypt_unit.sv @@
// XTEA block encryption unit: unrolled half-round pipeline with output skid stage.
//
// Usage
// - Input channel (in_*): one 64-bit plaintext block per transaction, first word in
//   the low 32 bits of in_tdata. Accepted when in_tvalid and in_tready are high.
// - Output channel (out_*): one 64-bit ciphertext block per transaction, same packing.
// - Configuration channel (cfg_*): writes key words 0..3 at cfg_index 0..3; other
//   indexes are ignored. cfg_ready is always high. Keys are only to be changed while
//   no block is in flight.
// - Throughput: one block per cycle while the skid register is empty. Each XTEA
//   round is split into two register stages (first word, then second word), so a
//   block passes 2*ROUNDS stages plus the output register.
// - Stalls: when the receiver holds out_tready low, one further result is parked in
//   the skid register, after which in_tready drops and the whole pipeline freezes;
//   nothing is dropped or repeated. in_tready comes straight from a register.
// - Reset (rst_n low, synchronous): clears all valid bits, the skid stage and the
//   key words to zero.
module xtea_block_encrypt_unit #(
  parameter int ROUNDS = xtea_pkg::ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [31:0] plain_first, [63:32] plain_second
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [xtea_pkg::BLOCK_W-1:0]  in_tdata,
  // out_tdata: [31:0] cipher_first, [63:32] cipher_second
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [xtea_pkg::BLOCK_W-1:0]  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]   cfg_data
);
  import xtea_pkg::*;

  localparam int STAGES = 2 * ROUNDS;

  // key registers
  word_t key_r [4];

  // pipeline: even stages update the first word, odd stages the second
  word_t y_r [STAGES];
  word_t z_r [STAGES];
  logic  v_r [STAGES];

  logic  adv;

  // output and skid registers
  logic                out_v_r;
  logic [BLOCK_W-1:0]  out_d_r;
  logic                skid_v_r;
  logic [BLOCK_W-1:0]  skid_d_r;
  logic [BLOCK_W-1:0]  exit_d;
  logic                exit_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_A: key_r[0] <= cfg_data;
        REG_KEY_B: key_r[1] <= cfg_data;
        REG_KEY_C: key_r[2] <= cfg_data;
        REG_KEY_D: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the skid stage is free
  assign adv       = !skid_v_r;
  assign in_tready = adv;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int    RND   = j / 2;
    localparam word_t SUM_Y = round_sum(RND);
    localparam word_t SUM_Z = round_sum(RND + 1);

    word_t y_src, z_src, y_nxt, z_nxt;
    logic  v_src;

    if (j == 0) begin : g_first
      assign y_src = in_tdata[WORD_W-1:0];
      assign z_src = in_tdata[BLOCK_W-1:WORD_W];
      assign v_src = in_tvalid;
    end else begin : g_chain
      assign y_src = y_r[j-1];
      assign z_src = z_r[j-1];
      assign v_src = v_r[j-1];
    end

    if (j % 2 == 0) begin : g_half_y
      assign y_nxt = y_src + mix_word(z_src, SUM_Y, key_r[SUM_Y[1:0]]);
      assign z_nxt = z_src;
    end else begin : g_half_z
      assign y_nxt = y_src;
      assign z_nxt = z_src + mix_word(y_src, SUM_Z, key_r[SUM_Z[12:11]]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        y_r[j] <= y_nxt;
        z_r[j] <= z_nxt;
      end
    end
  end

  assign exit_v = v_r[STAGES-1];
  assign exit_d = {z_r[STAGES-1], y_r[STAGES-1]};

  // output register with a single skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= exit_v;
    end else if (exit_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) out_d_r <= skid_d_r;
    end else if (!out_v_r || out_tready) begin
      out_d_r <= exit_d;
    end else begin
      skid_d_r <= exit_d;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

@@ rtl/core/xtea_chk.sv @@
// Port-level checker for the XTEA block encryption unit, with its bind.
module xtea_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [xtea_pkg::BLOCK_W-1:0]  in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [xtea_pkg::BLOCK_W-1:0]  out_tdata
);
  import xtea_pkg::*;

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // input only backs off while a result is waiting downstream
  a_ready_low_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with no pending result");

  // in_tready only drops after a stalled output transaction
  a_ready_fall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("in_tready dropped without an output stall");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // offered input holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("waiting input transaction changed");

endmodule

bind xtea_block_encrypt_unit xtea_chk u_xtea_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/xtea_block_encrypt_unit_tb.sv @@
// Self-checking testbench for the XTEA block encryption unit: key phases, corner and random blocks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xtea_pkg::*;

  localparam int N_ROUNDS       = ROUNDS_DEF;
  // Two register stages per round plus the output register
  localparam int PIPE_LATENCY   = 2 * N_ROUNDS + 1;
  // Cycles with no transaction on any channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the deliberate receiver hold-off, long enough to fill the pipeline
  localparam int HOLD_CYCLES    = 300;

  // Packed so that first sits in the low word, as on in_tdata/out_tdata
  typedef struct packed {
    word_t second;
    word_t first;
  } block_t;

  // Holds the key copy, works out each ciphertext and checks it on arrival
  class cipher_checker;
    word_t  key [4];
    block_t expected_ciphers [$];
    int     failures;
    int     rounds;

    function new(int n_rounds);
      rounds   = n_rounds;
      failures = 0;
      foreach (key[i]) key[i] = '0;
    endfunction

    // Indexes beyond the last key word are dropped, as the block does
    function void write_key(logic [CFG_IDX_W-1:0] idx, word_t value);
      if (idx <= REG_KEY_D) key[idx[1:0]] = value;
    endfunction

    // Half-round term: shifted copies of v, plus v, xored with sum plus key
    function word_t round_term(word_t v, word_t s, word_t k);
      word_t f;
      f = ((v << 4) ^ (v >> 5)) + v;
      return f ^ (s + k);
    endfunction

    function block_t encrypt_block(block_t plain);
      word_t  y;
      word_t  z;
      word_t  s;
      block_t c;
      y = plain.first;
      z = plain.second;
      s = '0;
      for (int r = 0; r < rounds; r++) begin
        y = y + round_term(z, s, key[s[1:0]]);
        s = s + SUM_STEP;
        z = z + round_term(y, s, key[s[12:11]]);
      end
      c.first  = y;
      c.second = z;
      return c;
    endfunction

    function void note_plain(block_t plain);
      expected_ciphers.push_back(encrypt_block(plain));
    endfunction

    function int pending();
      return expected_ciphers.size();
    endfunction

    task report(string msg);
      failures++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_cipher(block_t got);
      block_t want;
      if (expected_ciphers.size() == 0) begin
        report($sformatf("cipher block %h with no plaintext outstanding", got));
        return;
      end
      want = expected_ciphers.pop_front();
      if (got.first !== want.first)
        report($sformatf("cipher_first %h, want %h", got.first, want.first));
      if (got.second !== want.second)
        report($sformatf("cipher_second %h, want %h", got.second, want.second));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [BLOCK_W-1:0]   in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BLOCK_W-1:0]   out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [WORD_W-1:0]    cfg_data   = '0;

  cipher_checker sb = new(N_ROUNDS);

  // Idle controls shared between the phase sequence and the sender or receiver, and the watchdog's idle count
  bit tx_no_gap   = 1'b0;
  bit rx_no_stall = 1'b0;
  int rx_hold_len = 0;
  int idle_cycles = 0;

  // Corner plaintexts, packed {second, first}
  logic [63:0] corner_blocks [12] = '{
    64'h00000000_00000000, 64'hFFFFFFFF_FFFFFFFF,
    64'h00000000_FFFFFFFF, 64'hFFFFFFFF_00000000,
    64'h00000000_00000001, 64'h00000001_00000000,
    64'h00000000_80000000, 64'h80000000_00000000,
    64'hAAAAAAAA_55555555, 64'h55555555_AAAAAAAA,
    64'h80000000_7FFFFFFF, 64'h9ABCDEF0_12345678
  };

  xtea_block_encrypt_unit #(
    .ROUNDS (N_ROUNDS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: any transaction on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("xtea_block_encrypt_unit test failed");
        $finish;
      end
    end
  end

  // Receiver: random stall per transaction, plus the one-off long hold-off on request
  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end else begin
        stall = rx_no_stall ? 0 : $urandom_range(0, 19);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_cipher(out_tdata);
    end
  end

  // Leaves cfg_valid high so back-to-back writes never toggle it within a step
  task write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_key(idx, value);
  endtask

  // cfg_valid stays high afterwards; the caller drops it
  task load_key(word_t ka, word_t kb, word_t kc, word_t kd);
    write_reg(REG_KEY_A, ka);
    write_reg(REG_KEY_B, kb);
    write_reg(REG_KEY_C, kc);
    write_reg(REG_KEY_D, kd);
  endtask

  // Writes to unmapped indexes must leave the key untouched
  task stray_writes();
    write_reg(REG_KEY_D + 8'd1, $urandom);
    write_reg({CFG_IDX_W{1'b1}}, $urandom);
    write_reg(8'h80 | 8'($urandom_range(0, 127)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function int unsigned next_gap();
    return tx_no_gap ? 0 : $urandom_range(0, 19);
  endfunction

  // Mostly full-range words, with the odd extreme mixed in
  function word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task send_block(block_t blk, int unsigned gap);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    do @(posedge clk); while (!in_tready);
    sb.note_plain(blk);
  endtask

  // Keys may only change with nothing in flight: every block gives one result,
  // so an empty expectation queue means an empty pipeline
  task end_phase();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task run_random(int count);
    block_t blk;
    for (int i = 0; i < count; i++) begin
      // occasional flips give stretches with and without idling on each side
      if ($urandom_range(0, 31) == 0) tx_no_gap = !tx_no_gap;
      if ($urandom_range(0, 31) == 0) rx_no_stall = !rx_no_stall;
      blk.first  = rand_word();
      blk.second = rand_word();
      send_block(blk, next_gap());
    end
  endtask

  initial begin
    block_t blk;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Key left at its reset value of zero
    foreach (corner_blocks[i]) send_block(corner_blocks[i], next_gap());
    end_phase();

    // All-ones key, with unmapped writes that must change nothing
    load_key('1, '1, '1, '1);
    stray_writes();
    for (int i = 0; i < 6; i++) send_block(corner_blocks[i], next_gap());
    end_phase();

    // Byte-sequence key
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    cfg_valid <= 1'b0;
    run_random(150);
    end_phase();

    // Extreme words in every key slot
    load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    cfg_valid <= 1'b0;
    run_random(150);
    end_phase();

    // Long receiver hold-off while the sender offers back to back: the pipeline
    // and skid stage fill and in_tready must drop without losing a transaction
    load_key($urandom, $urandom, $urandom, $urandom);
    cfg_valid <= 1'b0;
    rx_hold_len = HOLD_CYCLES;
    for (int i = 0; i < 120; i++) begin
      blk.first  = $urandom;
      blk.second = $urandom;
      send_block(blk, 0);
    end
    run_random(60);
    end_phase();

    // Single key word changed on its own
    write_reg(REG_KEY_C, $urandom);
    cfg_valid <= 1'b0;
    run_random(180);
    end_phase();

    load_key($urandom, $urandom, $urandom, $urandom);
    stray_writes();
    run_random(180);
    end_phase();

    load_key($urandom, $urandom, $urandom, $urandom);
    cfg_valid <= 1'b0;
    run_random(180);
    end_phase();

    // Let any spurious late output show itself
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    if (sb.failures == 0) begin
      $display("xtea_block_encrypt_unit test passed");
    end else begin
      $display("xtea_block_encrypt_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/xtea_pkg.sv
rtl/core/xtea_block_encrypt_unit.sv
rtl/core/xtea_chk.sv
test/xtea_block_encrypt_unit_tb.sv
